/* rtl/core/fwrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrl_pkg
// Shared types and constants of the fixed-window rate limiter.
// ----------------------------------------------------------------------------
package fwrl_pkg;

  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] REQUEST_LIMIT_RST  = 16'd100;
  localparam logic [CFG_W-1:0] WINDOW_SECONDS_RST = 16'd60;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } slot_t;

endpackage

/* rtl/core/fixed_window_rate_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter
// Per-client fixed-window request limiter over a table of client slots.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request (in_client_key, in_now_seconds) with start high while
//   busy is low; the word is taken at that clock edge. busy then stays high
//   while the slot memory is swept, one entry read per cycle through its
//   single read port, and through the write-back state that follows, which
//   writes the updated or new entry unless the request is denied or untracked.
//   The result word (out_allowed, out_retry_after, out_untracked) appears on
//   the out_ ports for exactly one cycle with out_valid high, registered from
//   the write-back state. A new request may be taken in the same cycle as that
//   result strobe, and not before it, as busy stays high until then.
//   The receiver cannot stall: the result is gone after its strobe cycle.
//   Configuration words (cfg_we, cfg_index, cfg_wdata) are taken at once;
//   write them only while no request is in flight.
//   Reset sets request_limit to 100 and window_seconds to 60 and empties the
//   table at once (a fill count marks the occupied slots), with no clearing
//   pass.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter #(
  parameter int TABLE_ENTRIES = fwrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic [fwrl_pkg::KEY_W-1:0]         in_client_key,
  input  logic [fwrl_pkg::TIME_W-1:0]        in_now_seconds,
  // result channel
  output logic                               out_valid,
  output logic                               out_allowed,
  output logic [fwrl_pkg::COUNT_W-1:0]       out_retry_after,
  output logic                               out_untracked,
  // configuration port
  input  logic                               cfg_we,
  input  logic [fwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t state_r;

  // configuration
  logic [fwrl_pkg::CFG_W-1:0] limit_r;
  logic [fwrl_pkg::CFG_W-1:0] window_r;

  // request held during the sweep
  logic [fwrl_pkg::KEY_W-1:0]  key_r;
  logic [fwrl_pkg::TIME_W-1:0] now_r;

  // sweep control
  logic [CNT_W-1:0] fill_r;      // slots below this index are valid
  logic [CNT_W-1:0] addr_r;      // next address to read
  logic             chk_vld_r;   // read data returns this cycle
  logic [IDX_W-1:0] chk_idx_r;   // index of the returning entry

  // sweep results
  logic                         hit_found_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic [fwrl_pkg::COUNT_W-1:0] hit_cnt_r;
  logic [fwrl_pkg::TIME_W-1:0]  hit_start_r;
  logic [fwrl_pkg::COUNT_W-1:0] hit_elapsed_r;
  logic                         free_found_r;
  logic [IDX_W-1:0]             free_idx_r;

  // result registers
  logic                         out_valid_r;
  logic                         out_allowed_r;
  logic [fwrl_pkg::COUNT_W-1:0] out_retry_r;
  logic                         out_untracked_r;

  // memory ports
  logic            rd_en;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  fwrl_pkg::slot_t wr_data;
  fwrl_pkg::slot_t rd_data;

  // entry evaluation
  logic [fwrl_pkg::TIME_W-1:0] elapsed;
  logic                        entry_valid;
  logic                        entry_live;
  logic                        entry_match;

  // update decision
  logic                         under_limit;
  logic [fwrl_pkg::COUNT_W-1:0] count_nxt;
  logic                         fill_grow;

  fwrl_slot_ram #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Classify the entry that comes back from memory
  always_comb begin
    elapsed     = now_r - rd_data.start;
    entry_valid = (CNT_W'(chk_idx_r) < fill_r);
    entry_live  = entry_valid && (elapsed < {16'd0, window_r});
    entry_match = entry_live && (rd_data.key == key_r);
  end

  // Issue one read per cycle while sweeping
  assign rd_en = (state_r == ST_SCAN) && (addr_r != LAST_CNT);

  // Decide the write-back
  always_comb begin
    under_limit = (hit_cnt_r < limit_r);
    count_nxt   = hit_cnt_r + 16'd1;
    fill_grow   = !hit_found_r && free_found_r
                  && (CNT_W'(free_idx_r) == fill_r);
    wr_en       = 1'b0;
    wr_addr     = free_idx_r;
    wr_data     = '{key: key_r, count: 16'd1, start: now_r};
    if (state_r == ST_UPDATE) begin
      if (hit_found_r) begin
        wr_en   = under_limit;
        wr_addr = hit_idx_r;
        wr_data = '{key: key_r, count: count_nxt, start: hit_start_r};
      end else begin
        wr_en   = free_found_r;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= fwrl_pkg::REQUEST_LIMIT_RST;
      window_r <= fwrl_pkg::WINDOW_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwrl_pkg::REG_REQUEST_LIMIT:  limit_r  <= cfg_wdata;
        fwrl_pkg::REG_WINDOW_SECONDS: window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      addr_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      hit_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_UPDATE);
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            key_r        <= in_client_key;
            now_r        <= in_now_seconds;
            addr_r       <= '0;
            chk_vld_r    <= 1'b0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // advance the read address
          chk_vld_r <= rd_en;
          chk_idx_r <= addr_r[IDX_W-1:0];
          if (rd_en) begin
            addr_r <= addr_r + 1'b1;
          end
          // record first live match and first free slot
          if (chk_vld_r) begin
            if (entry_live) begin
              if (entry_match && !hit_found_r) begin
                hit_found_r   <= 1'b1;
                hit_idx_r     <= chk_idx_r;
                hit_cnt_r     <= rd_data.count;
                hit_start_r   <= rd_data.start;
                hit_elapsed_r <= elapsed[fwrl_pkg::COUNT_W-1:0];
              end
            end else if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= chk_idx_r;
            end
          end
          if (chk_vld_r && !rd_en) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // deny at the limit, flag a full table, otherwise pass
          out_allowed_r   <= !(hit_found_r && !under_limit);
          out_retry_r     <= (hit_found_r && !under_limit) ? (window_r - hit_elapsed_r)
                                                           : '0;
          out_untracked_r <= !hit_found_r && !free_found_r;
          if (fill_grow) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_allowed     = out_allowed_r;
  assign out_retry_after = out_retry_r;
  assign out_untracked   = out_untracked_r;

  // Assertions
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_UPDATE)
    else $error("result strobe without a write-back cycle");

  a_deny_has_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_allowed_r) |-> (out_retry_r != '0) && !out_untracked_r)
    else $error("denied result with zero retry or untracked flag");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LAST_CNT)
    else $error("fill count beyond table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

/* rtl/core/fwrl_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrl_slot_ram
// Slot table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fwrl_slot_ram #(
  parameter int DEPTH = fwrl_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  fwrl_pkg::slot_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output fwrl_pkg::slot_t      rd_data
);

  fwrl_pkg::slot_t mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* tb/tb_fixed_window_rate_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_window_rate_limiter
// Self-checking bench for the per-client fixed-window request limiter.
// ----------------------------------------------------------------------------
// A table of directed requests and register writes covers fresh and expired
// windows, denial at the limit, time wrap, a zero limit, a zero window, a full
// table and the largest retry time. Random phases then reprogram both
// registers and send bursts of requests from small pools of clients. Every
// result word is checked field by field against its typed directed verdict or
// a local model of the client table, with random sender gaps on most phases.
// ----------------------------------------------------------------------------
module tb_fixed_window_rate_limiter;

  localparam int KEY_W     = fwrl_pkg::KEY_W;
  localparam int TIME_W    = fwrl_pkg::TIME_W;
  localparam int COUNT_W   = fwrl_pkg::COUNT_W;
  localparam int CFG_W     = fwrl_pkg::CFG_W;
  localparam int CFG_IDX_W = fwrl_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = fwrl_pkg::REG_REQUEST_LIMIT;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = fwrl_pkg::REG_WINDOW_SECONDS;
  localparam logic [CFG_W-1:0]     REQUEST_LIMIT_RST  = fwrl_pkg::REQUEST_LIMIT_RST;
  localparam logic [CFG_W-1:0]     WINDOW_SECONDS_RST = fwrl_pkg::WINDOW_SECONDS_RST;

  localparam int ENTRIES          = 16;
  localparam int PHASES           = 30;
  localparam int WORDS_PER_PHASE  = 45;
  localparam int MAX_POOL         = 24;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 2 * (ENTRIES + 2);

  typedef struct packed {
    logic               allowed;
    logic [COUNT_W-1:0] retry_after;
    logic               untracked;
  } verdict_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     value;
    logic [KEY_W-1:0]     key;
    logic [TIME_W-1:0]    now_s;
    int                   reps;
    bit                   typed;
    verdict_t             want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     in_client_key;
  logic [TIME_W-1:0]    in_now_seconds;
  logic                 out_valid;
  logic                 out_allowed;
  logic [COUNT_W-1:0]   out_retry_after;
  logic                 out_untracked;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Local copy of the limiter state
  logic [CFG_W-1:0]   limit_reg;
  logic [CFG_W-1:0]   window_reg;
  logic               slot_used    [ENTRIES];
  logic [KEY_W-1:0]   slot_key_q   [ENTRIES];
  logic [COUNT_W-1:0] slot_count_q [ENTRIES];
  logic [TIME_W-1:0]  slot_start_q [ENTRIES];

  verdict_t pending_verdicts[$];
  row_t     plan[$];

  int mismatches     = 0;
  int requests_sent  = 0;
  int allowed_seen   = 0;
  int denied_seen    = 0;
  int untracked_seen = 0;
  int cfg_writes     = 0;
  int stall_cycles   = 0;

  fixed_window_rate_limiter #(.TABLE_ENTRIES(ENTRIES)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_client_key   (in_client_key),
    .in_now_seconds  (in_now_seconds),
    .out_valid       (out_valid),
    .out_allowed     (out_allowed),
    .out_retry_after (out_retry_after),
    .out_untracked   (out_untracked),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic verdict_t verdict(input logic a, input logic [COUNT_W-1:0] r,
                                       input logic u);
    verdict_t v;
    v.allowed     = a;
    v.retry_after = r;
    v.untracked   = u;
    return v;
  endfunction

  function automatic void clear_table();
    limit_reg  = REQUEST_LIMIT_RST;
    window_reg = WINDOW_SECONDS_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i]    = 1'b0;
      slot_key_q[i]   = '0;
      slot_count_q[i] = '0;
      slot_start_q[i] = '0;
    end
  endfunction

  // Look the client up, then count, deny, open a window or flag it untracked
  function automatic verdict_t judge_request(input logic [KEY_W-1:0] key,
                                             input logic [TIME_W-1:0] now_s);
    verdict_t          v;
    int                hit;
    int                spare;
    logic [TIME_W-1:0] age;
    v     = verdict(1'b1, '0, 1'b0);
    hit   = -1;
    spare = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      age = now_s - slot_start_q[i];
      if (slot_used[i] && age < {16'd0, window_reg}) begin
        if (hit < 0 && slot_key_q[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit >= 0) begin
      if (slot_count_q[hit] < limit_reg) begin
        slot_count_q[hit] = slot_count_q[hit] + 1'b1;
      end else begin
        age           = now_s - slot_start_q[hit];
        v.allowed     = 1'b0;
        v.retry_after = window_reg - age[COUNT_W-1:0];
      end
    end else if (spare >= 0) begin
      slot_used[spare]    = 1'b1;
      slot_key_q[spare]   = key;
      slot_count_q[spare] = 16'd1;
      slot_start_q[spare] = now_s;
    end else begin
      v.untracked = 1'b1;
    end
    return v;
  endfunction

  function automatic row_t req_row(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now_s,
                                   input int reps, input bit typed, input verdict_t want);
    row_t r;
    r.kind    = ROW_REQUEST;
    r.cfg_idx = '0;
    r.value   = '0;
    r.key     = key;
    r.now_s   = now_s;
    r.reps    = reps;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    row_t r;
    r         = req_row('0, '0, 0, 1'b0, verdict(1'b0, '0, 1'b0));
    r.kind    = ROW_CONFIG;
    r.cfg_idx = idx;
    r.value   = val;
    return r;
  endfunction

  // Called on a falling edge; hold start high until the word is taken
  task automatic issue_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now_s,
                               input bit typed, input verdict_t want);
    verdict_t model_v;
    in_client_key  = key;
    in_now_seconds = now_s;
    start          = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    model_v = judge_request(key, now_s);
    pending_verdicts.push_back(typed ? want : model_v);
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop start for a burst; half the time let the block go idle first
  task automatic pause_sender(input int cycles);
    start = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      while (busy !== 1'b0) @(negedge clk);
    end
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_until_drained();
    start = 1'b0;
    while (pending_verdicts.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == REG_REQUEST_LIMIT) limit_reg = val;
    else if (idx == REG_WINDOW_SECONDS) window_reg = val;
    cfg_writes++;
  endtask

  // Check each result word against the oldest pending one
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (out_allowed === 1'b1) allowed_seen++;
      else denied_seen++;
      if (out_untracked === 1'b1) untracked_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with none pending: allowed %0d retry %0d untracked %0d",
                 $time, out_allowed, out_retry_after, out_untracked);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_allowed !== want.allowed) begin
          mismatches++;
          $display("%0t ns: allowed mismatch: expected %0d, got %0d",
                   $time, want.allowed, out_allowed);
        end
        if (out_retry_after !== want.retry_after) begin
          mismatches++;
          $display("%0t ns: retry_after mismatch: expected %0d, got %0d",
                   $time, want.retry_after, out_retry_after);
        end
        if (out_untracked !== want.untracked) begin
          mismatches++;
          $display("%0t ns: untracked mismatch: expected %0d, got %0d",
                   $time, want.untracked, out_untracked);
        end
      end
    end
  end

  // Stop a run in which nothing moves
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || out_valid === 1'b1 || cfg_we === 1'b1 ||
        (start === 1'b1 && busy === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]  pool_keys [MAX_POOL];
    int                pool_size;
    int                idle_mode;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  last_key;
    logic [TIME_W-1:0] clock_now;
    logic [CFG_W-1:0]  new_limit;
    logic [CFG_W-1:0]  new_window;
    int                pick;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_client_key  = '0;
    in_now_seconds = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    clear_table();

    // Directed rows; typed verdicts only where they are obvious
    plan.push_back(req_row(32'h0A00_0001, 32'd1000, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h0000_0000, 32'h0000_0000, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 16'd2));
    plan.push_back(cfg_row(REG_WINDOW_SECONDS, 16'd10));
    // count up to the limit, deny, then reopen once the window has run out
    plan.push_back(req_row(32'h0A00_0002, 32'd500, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h0A00_0002, 32'd501, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h0A00_0002, 32'd503, 1, 1'b1, verdict(1'b0, 16'd7, 1'b0)));
    plan.push_back(req_row(32'h0A00_0002, 32'd509, 1, 1'b1, verdict(1'b0, 16'd1, 1'b0)));
    plan.push_back(req_row(32'h0A00_0002, 32'd510, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    // window that straddles the time wrap
    plan.push_back(req_row(32'hC0A8_0001, 32'hFFFF_FFFC, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'hC0A8_0001, 32'hFFFF_FFFF, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'hC0A8_0001, 32'h0000_0002, 1, 1'b1, verdict(1'b0, 16'd4, 1'b0)));
    // zero limit: first word of a window passes, the next is denied
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 16'd0));
    plan.push_back(req_row(32'h7F00_0001, 32'd2, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h7F00_0001, 32'd2, 1, 1'b1, verdict(1'b0, 16'd10, 1'b0)));
    // zero window: nothing stays live
    plan.push_back(cfg_row(REG_WINDOW_SECONDS, 16'd0));
    plan.push_back(req_row(32'h7F00_0001, 32'd2, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h7F00_0001, 32'd2, 1, 1'b1, verdict(1'b1, 16'd0, 1'b0)));
    // fill the whole table, then overflow it
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 16'hFFFF));
    plan.push_back(cfg_row(REG_WINDOW_SECONDS, 16'hFFFF));
    plan.push_back(req_row(32'h55AA_0000, 32'h8000_0000, ENTRIES, 1'b0,
                           verdict(1'b0, 16'd0, 1'b0)));
    plan.push_back(req_row(32'h1234_5678, 32'h8000_0001, 1, 1'b1, verdict(1'b1, 16'd0, 1'b1)));
    plan.push_back(req_row(32'h55AA_0003, 32'h8000_0001, 1, 1'b0, verdict(1'b0, 16'd0, 1'b0)));
    // longest possible retry time
    plan.push_back(cfg_row(REG_REQUEST_LIMIT, 16'd0));
    plan.push_back(req_row(32'h55AA_0005, 32'h8000_0000, 1, 1'b1, verdict(1'b0, 16'hFFFF, 1'b0)));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CONFIG) begin
        wait_until_drained();
        write_register(plan[r].cfg_idx, plan[r].value);
      end else begin
        for (int j = 0; j < plan[r].reps; j++) begin
          issue_request(plan[r].key + j, plan[r].now_s, plan[r].typed, plan[r].want);
        end
      end
    end

    // Random phases: new settings, a pool of clients, bursts of requests
    clock_now = $urandom;
    last_key  = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      wait_until_drained();
      case ($urandom_range(0, 7))
        0:       new_limit = 16'd0;
        1:       new_limit = 16'd1;
        2, 3:    new_limit = 16'($urandom_range(2, 6));
        4:       new_limit = 16'hFFFF;
        5:       new_limit = 16'($urandom);
        default: new_limit = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 15))
        0:       new_window = 16'd1;
        1:       new_window = 16'hFFFF;
        2:       new_window = 16'd0;
        3:       new_window = 16'($urandom);
        4, 5, 6: new_window = 16'($urandom_range(2, 8));
        default: new_window = 16'($urandom_range(5, 40));
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_register(REG_REQUEST_LIMIT, new_limit);
        write_register(REG_WINDOW_SECONDS, new_window);
      end else begin
        write_register(REG_WINDOW_SECONDS, new_window);
        write_register(REG_REQUEST_LIMIT, new_limit);
      end

      pool_size = $urandom_range(2, MAX_POOL);
      for (int k = 0; k < MAX_POOL; k++) pool_keys[k] = $urandom;
      // some phases start just short of the time wrap
      case ($urandom_range(0, 3))
        0:       clock_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
        1:       clock_now = $urandom;
        default: clock_now = clock_now + $urandom_range(0, 100);
      endcase
      // last phases run without sender gaps
      idle_mode = (p >= PHASES - 3) ? 0 : $urandom_range(0, 2);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8)       key = last_key;
        else if (pick < 18) key = pool_keys[$urandom_range(0, pool_size - 1)];
        else                key = $urandom;
        last_key = key;

        pick = $urandom_range(0, 19);
        if (pick < 12)      clock_now = clock_now + $urandom_range(0, 1);
        else if (pick < 17) clock_now = clock_now + $urandom_range(0, window_reg);
        else if (pick < 19) clock_now = clock_now + window_reg + $urandom_range(0, 3);
        else                clock_now = $urandom;

        issue_request(key, clock_now, 1'b0, verdict(1'b0, '0, 1'b0));

        if ((idle_mode == 1 && $urandom_range(0, 9) == 0) ||
            (idle_mode == 2 && $urandom_range(0, 2) == 0)) begin
          pause_sender($urandom_range(1, 12));
        end
      end
    end

    // Drain and let the block settle
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d requests and %0d register writes over %0d random phases.",
             requests_sent, cfg_writes, PHASES);
    $display("Results: %0d allowed, %0d denied, %0d untracked; %0d field mismatches.",
             allowed_seen, denied_seen, untracked_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
